/* sv/console_nesting_scanner_unit_defines.svh */
// assertion macros for the console nesting scanner
// used by the top level, needs clk and rst_n in scope where expanded
`ifndef CONSOLE_NESTING_SCANNER_UNIT_DEFINES_SVH
`define CONSOLE_NESTING_SCANNER_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define CNS_ASSERT(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);
`define CNS_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define CNS_ASSERT(label, expr, msg)
`define CNS_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

/* sv/cns_pkg.sv */
// types, codes and helpers for the console nesting scanner
// no dependencies
package cns_pkg;

    typedef struct packed {
        logic       operation;
        logic [7:0] char_byte;
        logic       end_of_line;
    } in_item_t;

    typedef struct packed {
        logic [15:0] nest_depth;
        logic [2:0]  open_kind;
        logic [1:0]  scan_mode;
        logic        input_complete;
    } out_item_t;

    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_ABORT = 1'b1;

    localparam logic [2:0] KIND_NONE   = 3'd0;
    localparam logic [2:0] KIND_SQUARE = 3'd1;
    localparam logic [2:0] KIND_PAREN  = 3'd2;
    localparam logic [2:0] KIND_BRACE  = 3'd3;
    localparam logic [2:0] KIND_DEEP   = 3'd4;

    localparam logic [1:0] SCAN_CODE   = 2'd0;
    localparam logic [1:0] SCAN_QUOTED = 2'd1;
    localparam logic [1:0] SCAN_BRACE  = 2'd2;
    localparam logic [1:0] SCAN_RAW    = 2'd3;

    localparam logic [7:0] CH_QUOTE    = 8'h22;
    localparam logic [7:0] CH_PERCENT  = 8'h25;
    localparam logic [7:0] CH_LPAREN   = 8'h28;
    localparam logic [7:0] CH_RPAREN   = 8'h29;
    localparam logic [7:0] CH_LSQUARE  = 8'h5b;
    localparam logic [7:0] CH_RSQUARE  = 8'h5d;
    localparam logic [7:0] CH_CARET    = 8'h5e;
    localparam logic [7:0] CH_LBRACE   = 8'h7b;
    localparam logic [7:0] CH_RBRACE   = 8'h7d;

    function automatic logic [15:0] sat_inc16(input logic [15:0] v);
        sat_inc16 = (v == 16'hffff) ? v : v + 16'd1;
    endfunction

    function automatic logic [15:0] sat_dec16(input logic [15:0] v);
        sat_dec16 = (v == 16'd0) ? v : v - 16'd1;
    endfunction

endpackage

/* sv/cns_ram.sv */
// generic single-write, single-read ram with registered read data
// no dependencies
module cns_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

/* sv/console_nesting_scanner_unit.sv */
// console nesting scanner top level: per-byte scan state and bracket stack
// depends on cns_pkg, cns_ram and console_nesting_scanner_unit_defines.svh
//
// Takes one input byte per cycle and returns one result per byte, in order.
// The edge that takes a byte updates the scan state and starts the read of the
// new top of the bracket stack from its ram. The middle stage then forms the
// open kind from the read data and loads the output register once it is free.
// A new byte can be taken every cycle. The input stalls only while the middle
// stage and the output register both hold items and the output is stalled.
// The kind of a level pushed in the same cycle is forwarded around the ram.
// The stack ram needs no clearing after reset: only entries below the
// current depth are ever read. An abort clears all scan state at once.
`include "console_nesting_scanner_unit_defines.svh"

module console_nesting_scanner_unit #(
    parameter int STACK_DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              byte_valid,
    output logic              byte_stall,
    input  cns_pkg::in_item_t byte_item,
    output logic              result_valid,
    input  logic              result_stall,
    output cns_pkg::out_item_t result_item
);

    localparam int AW = $clog2(STACK_DEPTH);
    localparam logic [16:0] SD = 17'(STACK_DEPTH);

    typedef enum logic [2:0] {
        MODE_CODE,
        MODE_QUOTED,
        MODE_BRACE,
        MODE_RAW,
        MODE_CODE_PCT,
        MODE_RAW_CLOSE
    } mode_t;

    mode_t       mode_reg, mode_next;
    logic        esc_reg, esc_next;
    logic [15:0] pct_reg, pct_next;
    logic [15:0] raw_reg, raw_next;
    logic [15:0] brace_reg, brace_next;
    logic [15:0] depth_reg, depth_next;

    logic        mid_valid_reg;
    logic [15:0] mid_depth_reg;
    logic [1:0]  mid_mode_reg;
    logic        mid_done_reg;
    logic [2:0]  mid_kind_reg;
    logic        mid_mem_reg;
    logic        mid_byp_reg;
    logic [1:0]  mid_byp_kind_reg;

    logic        accept;
    logic        out_free;
    logic        mid_move;
    logic        open_req;
    logic [1:0]  open_kind;
    logic        push;
    logic [AW-1:0] push_addr;
    logic [AW-1:0] top_addr;
    logic        eol_eff;
    logic [1:0]  shown;
    logic [2:0]  fixed_kind;
    logic        use_mem;
    logic [15:0] top_idx;
    logic [1:0]  ram_rdata;
    logic [2:0]  mid_kind;
    logic [7:0]  c;
    logic        eol;

    assign out_free   = !result_valid || !result_stall;
    assign mid_move   = mid_valid_reg && out_free;
    assign byte_stall = mid_valid_reg && !out_free;
    assign accept     = byte_valid && !byte_stall;
    assign c          = byte_item.char_byte;
    assign eol        = byte_item.end_of_line;

    always_comb
    begin
        mode_next  = mode_reg;
        esc_next   = esc_reg;
        pct_next   = pct_reg;
        raw_next   = raw_reg;
        brace_next = brace_reg;
        depth_next = depth_reg;
        open_req   = 1'b0;
        open_kind  = cns_pkg::KIND_BRACE[1:0];
        eol_eff    = eol;
        if (byte_item.operation == cns_pkg::OP_ABORT)
        begin
            mode_next  = MODE_CODE;
            esc_next   = 1'b0;
            pct_next   = '0;
            raw_next   = '0;
            brace_next = '0;
            depth_next = '0;
            eol_eff    = 1'b0;
        end
        else
        begin
            case (mode_reg)
                MODE_QUOTED:
                begin
                    if (esc_reg)
                        esc_next = 1'b0;
                    else if (c == cns_pkg::CH_CARET && !eol)
                        esc_next = 1'b1;
                    else if (c == cns_pkg::CH_QUOTE)
                        mode_next = MODE_CODE;
                end
                MODE_BRACE:
                begin
                    if (esc_reg)
                        esc_next = 1'b0;
                    else if (c == cns_pkg::CH_CARET && !eol)
                        esc_next = 1'b1;
                    else if (c == cns_pkg::CH_LBRACE)
                    begin
                        open_req   = 1'b1;
                        brace_next = cns_pkg::sat_inc16(brace_reg);
                    end
                    else if (c == cns_pkg::CH_RBRACE)
                    begin
                        depth_next = cns_pkg::sat_dec16(depth_reg);
                        brace_next = cns_pkg::sat_dec16(brace_reg);
                        if (brace_next == 16'd0)
                            mode_next = MODE_CODE;
                    end
                end
                MODE_RAW:
                begin
                    if (c == cns_pkg::CH_RBRACE && !eol)
                    begin
                        pct_next  = '0;
                        mode_next = MODE_RAW_CLOSE;
                    end
                end
                MODE_CODE_PCT:
                begin
                    if (pct_reg == 16'd1 && c == cns_pkg::CH_QUOTE)
                    begin
                        pct_next  = '0;
                        mode_next = MODE_QUOTED;
                    end
                    else if (c == cns_pkg::CH_PERCENT)
                    begin
                        pct_next = cns_pkg::sat_inc16(pct_reg);
                        if (eol)
                        begin
                            pct_next  = '0;
                            mode_next = MODE_CODE;
                        end
                    end
                    else if (c == cns_pkg::CH_LBRACE)
                    begin
                        raw_next  = pct_reg;
                        open_req  = 1'b1;
                        pct_next  = '0;
                        mode_next = MODE_RAW;
                    end
                    else
                    begin
                        pct_next  = '0;
                        mode_next = MODE_CODE;
                    end
                end
                MODE_RAW_CLOSE:
                begin
                    if (c == cns_pkg::CH_PERCENT)
                    begin
                        pct_next = cns_pkg::sat_inc16(pct_reg);
                        if (eol)
                        begin
                            if (pct_next >= raw_reg)
                            begin
                                depth_next = cns_pkg::sat_dec16(depth_reg);
                                raw_next   = '0;
                                pct_next   = '0;
                                mode_next  = MODE_CODE;
                            end
                            else
                            begin
                                pct_next  = '0;
                                mode_next = MODE_RAW;
                            end
                        end
                    end
                    else if (pct_reg != 16'd0 && pct_reg >= raw_reg)
                    begin
                        depth_next = cns_pkg::sat_dec16(depth_reg);
                        raw_next   = '0;
                        pct_next   = '0;
                        mode_next  = MODE_CODE;
                    end
                    else
                    begin
                        pct_next  = '0;
                        mode_next = MODE_RAW;
                        if (c == cns_pkg::CH_RBRACE && !eol)
                            mode_next = MODE_RAW_CLOSE;
                    end
                end
                default:
                begin
                    mode_next = MODE_CODE;
                    case (c)
                        cns_pkg::CH_QUOTE: mode_next = MODE_QUOTED;
                        cns_pkg::CH_LSQUARE:
                        begin
                            open_req  = 1'b1;
                            open_kind = cns_pkg::KIND_SQUARE[1:0];
                        end
                        cns_pkg::CH_LPAREN:
                        begin
                            open_req  = 1'b1;
                            open_kind = cns_pkg::KIND_PAREN[1:0];
                        end
                        cns_pkg::CH_RSQUARE, cns_pkg::CH_RPAREN:
                            depth_next = cns_pkg::sat_dec16(depth_reg);
                        cns_pkg::CH_LBRACE:
                        begin
                            open_req   = 1'b1;
                            brace_next = cns_pkg::sat_inc16(brace_reg);
                            mode_next  = MODE_BRACE;
                        end
                        cns_pkg::CH_PERCENT:
                        begin
                            if (!eol)
                            begin
                                pct_next  = 16'd1;
                                mode_next = MODE_CODE_PCT;
                            end
                        end
                        default: ;
                    endcase
                end
            endcase
            if (open_req)
                depth_next = cns_pkg::sat_inc16(depth_reg);
            if (eol)
            begin
                esc_next = 1'b0;
                if (mode_next == MODE_QUOTED || mode_next == MODE_CODE_PCT)
                begin
                    mode_next = MODE_CODE;
                    pct_next  = '0;
                end
            end
        end
    end

    // stack write and read of the new top
    assign push      = accept && open_req && ({1'b0, depth_reg} < SD);
    assign push_addr = depth_reg[AW-1:0];
    assign top_idx   = depth_next - 16'd1;
    assign top_addr  = top_idx[AW-1:0];

    always_comb
    begin
        use_mem    = 1'b0;
        fixed_kind = cns_pkg::KIND_NONE;
        if (depth_next == 16'd0)
            fixed_kind = cns_pkg::KIND_NONE;
        else if ({1'b0, depth_next} > SD)
            fixed_kind = cns_pkg::KIND_DEEP;
        else
            use_mem = 1'b1;
    end

    always_comb
    begin
        case (mode_next)
            MODE_QUOTED:    shown = cns_pkg::SCAN_QUOTED;
            MODE_BRACE:     shown = cns_pkg::SCAN_BRACE;
            MODE_RAW:       shown = cns_pkg::SCAN_RAW;
            MODE_RAW_CLOSE: shown = cns_pkg::SCAN_RAW;
            default:        shown = cns_pkg::SCAN_CODE;
        endcase
    end

    cns_ram #(
        .WIDTH (2),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (push),
        .waddr (push_addr),
        .wdata (open_kind),
        .re    (accept),
        .raddr (top_addr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        mid_kind = mid_kind_reg;
        if (mid_mem_reg)
            mid_kind = mid_byp_reg ? {1'b0, mid_byp_kind_reg} : {1'b0, ram_rdata};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_CODE;
            esc_reg          <= 1'b0;
            pct_reg          <= '0;
            raw_reg          <= '0;
            brace_reg        <= '0;
            depth_reg        <= '0;
            mid_valid_reg    <= 1'b0;
            mid_depth_reg    <= '0;
            mid_mode_reg     <= cns_pkg::SCAN_CODE;
            mid_done_reg     <= 1'b0;
            mid_kind_reg     <= cns_pkg::KIND_NONE;
            mid_mem_reg      <= 1'b0;
            mid_byp_reg      <= 1'b0;
            mid_byp_kind_reg <= '0;
            result_valid     <= 1'b0;
            result_item      <= '0;
        end
        else
        begin
            if (accept)
            begin
                mode_reg         <= mode_next;
                esc_reg          <= esc_next;
                pct_reg          <= pct_next;
                raw_reg          <= raw_next;
                brace_reg        <= brace_next;
                depth_reg        <= depth_next;
                mid_depth_reg    <= depth_next;
                mid_mode_reg     <= shown;
                mid_done_reg     <= eol_eff && (depth_next == 16'd0);
                mid_kind_reg     <= fixed_kind;
                mid_mem_reg      <= use_mem;
                mid_byp_reg      <= push && (push_addr == top_addr);
                mid_byp_kind_reg <= open_kind;
            end
            if (accept)
                mid_valid_reg <= 1'b1;
            else if (mid_move)
                mid_valid_reg <= 1'b0;
            if (mid_move)
            begin
                result_valid               <= 1'b1;
                result_item.nest_depth     <= mid_depth_reg;
                result_item.open_kind      <= mid_kind;
                result_item.scan_mode      <= mid_mode_reg;
                result_item.input_complete <= mid_done_reg;
            end
            else if (!result_stall)
            begin
                result_valid <= 1'b0;
            end
        end
    end

    `CNS_ASSERT(a_stall_only_when_full,
        !byte_stall || (mid_valid_reg && result_valid),
        "stall with free stage")
    `CNS_ASSERT_NEXT(a_abort_clears,
        accept && byte_item.operation == cns_pkg::OP_ABORT,
        depth_reg == 16'd0 && mode_reg == MODE_CODE && brace_reg == 16'd0,
        "abort left state")
    `CNS_ASSERT(a_brace_mode_match,
        (brace_reg != 16'd0) == (mode_reg == MODE_BRACE),
        "brace depth out of step with mode")
    `CNS_ASSERT(a_raw_depth_mode,
        raw_reg == 16'd0 || mode_reg == MODE_RAW || mode_reg == MODE_RAW_CLOSE,
        "raw depth outside raw string")

endmodule

/* tb/console_nesting_scanner_unit_test.sv */
`timescale 1ns / 100ps
// testbench for console_nesting_scanner_unit: directed table, a deep-stack burst, then random
// console text, scored against a byte-level scanner predictor or, for typed table rows, their
// own expected results; depends on cns_pkg and the console_nesting_scanner_unit rtl
module console_nesting_scanner_unit_test;
    import cns_pkg::*;

    localparam int STACK_DEPTH   = 1024;
    localparam int RANDOM_ITEMS  = 750;
    localparam int HOLD_CYCLES   = 120;
    localparam int QUIET_LIMIT   = 2000;

    typedef enum logic [2:0] {
        ST_CODE      = 3'd0,
        ST_QUOTED    = 3'd1,
        ST_BRACE     = 3'd2,
        ST_RAW       = 3'd3,
        ST_PCT_RUN   = 3'd4,
        ST_RAW_CLOSE = 3'd5
    } scan_state_t;

    typedef struct packed {
        in_item_t  item;
        logic      typed;
        out_item_t want;
    } plan_row_t;

    localparam out_item_t NO_WANT = '0;

    localparam plan_row_t PLAN [0:25] = '{
        '{'{OP_SCAN, 8'h61, 1'b1}, 1'b1, '{16'd0, KIND_NONE, SCAN_CODE, 1'b1}},
        '{'{OP_SCAN, 8'hff, 1'b0}, 1'b1, '{16'd0, KIND_NONE, SCAN_CODE, 1'b0}},
        '{'{OP_SCAN, CH_RSQUARE, 1'b1}, 1'b1, '{16'd0, KIND_NONE, SCAN_CODE, 1'b1}},
        '{'{OP_SCAN, CH_LSQUARE, 1'b0}, 1'b1, '{16'd1, KIND_SQUARE, SCAN_CODE, 1'b0}},
        '{'{OP_SCAN, CH_LPAREN, 1'b0}, 1'b1, '{16'd2, KIND_PAREN, SCAN_CODE, 1'b0}},
        '{'{OP_SCAN, CH_QUOTE, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_CARET, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_QUOTE, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, 8'h00, 1'b1}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_LBRACE, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_CARET, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_RBRACE, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_RBRACE, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_PERCENT, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_QUOTE, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_PERCENT, 1'b1}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_PERCENT, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_PERCENT, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_LBRACE, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_RBRACE, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_PERCENT, 1'b1}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_RBRACE, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_PERCENT, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, CH_PERCENT, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_SCAN, 8'h00, 1'b0}, 1'b0, NO_WANT},
        '{'{OP_ABORT, 8'hff, 1'b1}, 1'b1, '{16'd0, KIND_NONE, SCAN_CODE, 1'b0}}
    };

    logic      clk = 1'b0;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    in_item_t  byte_item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result_item;

    // scanner predictor state
    scan_state_t scan_state;
    logic        esc_armed;
    logic [15:0] pct_count;
    logic [15:0] raw_fence;
    logic [15:0] brace_nest;
    logic [15:0] level_count;
    bit   [1:0]  level_kind [0:STACK_DEPTH-1];

    out_item_t awaited_scans [$];
    int        mismatch_count = 0;
    int        quiet_cycles = 0;
    int        random_sent = 0;
    bit        send_busy = 1'b1;
    bit        recv_busy = 1'b1;
    bit        long_hold_req = 1'b0;

    console_nesting_scanner_unit #(.STACK_DEPTH(STACK_DEPTH)) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .byte_valid   (byte_valid),
        .byte_stall   (byte_stall),
        .byte_item    (byte_item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result_item  (result_item)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic logic [15:0] bump_up(input logic [15:0] v);
        return (v == 16'hffff) ? v : v + 16'd1;
    endfunction

    function automatic logic [15:0] bump_down(input logic [15:0] v);
        return (v == 16'd0) ? v : v - 16'd1;
    endfunction

    function automatic int gap_len(input bit busy);
        int pick;
        pick = $urandom_range(0, 99);
        if (!busy || pick < 70)
            return 0;
        if (pick < 92)
            return $urandom_range(1, 3);
        if (pick < 98)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic logic [7:0] plain_byte();
        return 8'($urandom_range(8'h20, 8'h7e));
    endfunction

    task automatic clear_scanner();
        scan_state  = ST_CODE;
        esc_armed   = 1'b0;
        pct_count   = '0;
        raw_fence   = '0;
        brace_nest  = '0;
        level_count = '0;
    endtask

    task automatic push_level(input logic [1:0] kind);
        if (level_count < STACK_DEPTH)
            level_kind[level_count] = kind;
        level_count = bump_up(level_count);
    endtask

    task automatic code_char(input logic [7:0] c, input logic eol);
        case (c)
            CH_QUOTE:   scan_state = ST_QUOTED;
            CH_LSQUARE: push_level(KIND_SQUARE[1:0]);
            CH_LPAREN:  push_level(KIND_PAREN[1:0]);
            CH_RSQUARE, CH_RPAREN: level_count = bump_down(level_count);
            CH_LBRACE:
            begin
                push_level(KIND_BRACE[1:0]);
                brace_nest = bump_up(brace_nest);
                scan_state = ST_BRACE;
            end
            CH_PERCENT:
            begin
                if (!eol)
                begin
                    pct_count  = 16'd1;
                    scan_state = ST_PCT_RUN;
                end
            end
            default: ;
        endcase
    endtask

    task automatic raw_char(input logic [7:0] c, input logic eol);
        if (c == CH_RBRACE && !eol)
        begin
            pct_count  = '0;
            scan_state = ST_RAW_CLOSE;
        end
    endtask

    task automatic close_raw();
        level_count = bump_down(level_count);
        raw_fence   = '0;
        pct_count   = '0;
        scan_state  = ST_CODE;
    endtask

    task automatic advance_scanner(input in_item_t it, output out_item_t r);
        logic [7:0] c;
        logic       eol;
        c   = it.char_byte;
        eol = it.end_of_line;
        if (it.operation == OP_ABORT)
        begin
            clear_scanner();
            eol = 1'b0;
        end
        else
        begin
            case (scan_state)
                ST_QUOTED:
                begin
                    if (esc_armed)
                        esc_armed = 1'b0;
                    else if (c == CH_CARET && !eol)
                        esc_armed = 1'b1;
                    else if (c == CH_QUOTE)
                        scan_state = ST_CODE;
                end
                ST_BRACE:
                begin
                    if (esc_armed)
                        esc_armed = 1'b0;
                    else if (c == CH_CARET && !eol)
                        esc_armed = 1'b1;
                    else if (c == CH_LBRACE)
                    begin
                        push_level(KIND_BRACE[1:0]);
                        brace_nest = bump_up(brace_nest);
                    end
                    else if (c == CH_RBRACE)
                    begin
                        level_count = bump_down(level_count);
                        brace_nest  = bump_down(brace_nest);
                        if (brace_nest == 16'd0)
                            scan_state = ST_CODE;
                    end
                end
                ST_RAW: raw_char(c, eol);
                ST_PCT_RUN:
                begin
                    if (pct_count == 16'd1 && c == CH_QUOTE)
                    begin
                        pct_count  = '0;
                        scan_state = ST_CODE;
                        code_char(c, eol);
                    end
                    else if (c == CH_PERCENT)
                    begin
                        pct_count = bump_up(pct_count);
                        if (eol)
                        begin
                            pct_count  = '0;
                            scan_state = ST_CODE;
                        end
                    end
                    else if (c == CH_LBRACE)
                    begin
                        raw_fence = pct_count;
                        push_level(KIND_BRACE[1:0]);
                        pct_count  = '0;
                        scan_state = ST_RAW;
                    end
                    else
                    begin
                        pct_count  = '0;
                        scan_state = ST_CODE;
                    end
                end
                ST_RAW_CLOSE:
                begin
                    if (c == CH_PERCENT)
                    begin
                        pct_count = bump_up(pct_count);
                        if (eol)
                        begin
                            if (pct_count >= raw_fence)
                                close_raw();
                            else
                            begin
                                pct_count  = '0;
                                scan_state = ST_RAW;
                            end
                        end
                    end
                    else if (pct_count > 16'd0 && pct_count >= raw_fence)
                        close_raw();
                    else
                    begin
                        pct_count  = '0;
                        scan_state = ST_RAW;
                        raw_char(c, eol);
                    end
                end
                default:
                begin
                    scan_state = ST_CODE;
                    code_char(c, eol);
                end
            endcase
            if (eol)
            begin
                esc_armed = 1'b0;
                if (scan_state == ST_QUOTED || scan_state == ST_PCT_RUN)
                begin
                    scan_state = ST_CODE;
                    pct_count  = '0;
                end
            end
        end

        r.nest_depth = level_count;
        if (level_count == 16'd0)
            r.open_kind = KIND_NONE;
        else if (level_count > STACK_DEPTH)
            r.open_kind = KIND_DEEP;
        else
            r.open_kind = {1'b0, level_kind[level_count - 16'd1]};
        case (scan_state)
            ST_QUOTED:            r.scan_mode = SCAN_QUOTED;
            ST_BRACE:             r.scan_mode = SCAN_BRACE;
            ST_RAW, ST_RAW_CLOSE: r.scan_mode = SCAN_RAW;
            default:              r.scan_mode = SCAN_CODE;
        endcase
        r.input_complete = eol && (level_count == 16'd0);
    endtask

    task automatic flag_mismatch(input string what);
        mismatch_count++;
        $display("mismatch at %0t: %s", $realtime, what);
    endtask

    task automatic offer_byte(input in_item_t it, input logic typed, input out_item_t want);
        int        gap;
        out_item_t calc;
        gap = gap_len(send_busy);
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        byte_item  <= it;
        do
            @(posedge clk);
        while (byte_stall !== 1'b0);
        advance_scanner(it, calc);
        awaited_scans.push_back(typed ? want : calc);
    endtask

    task automatic emit_raw(input logic [7:0] c, input logic eol);
        offer_byte('{OP_SCAN, c, eol}, 1'b0, NO_WANT);
        random_sent++;
    endtask

    // a stray end of line now and then breaks a sequence
    task automatic emit(input logic [7:0] c);
        emit_raw(c, $urandom_range(0, 99) < 3);
    endtask

    task automatic drain_results();
        byte_valid <= 1'b0;
        while (awaited_scans.size() != 0)
            @(posedge clk);
        @(posedge clk);
    endtask

    task automatic random_phrase();
        int         pick;
        int         k;
        int         nest;
        logic [7:0] b;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            emit_raw(8'($urandom_range(0, 255)), $urandom_range(0, 99) < 15);
        else if (pick < 30)
        begin
            if (level_count > 8 || $urandom_range(0, 1))
                emit($urandom_range(0, 1) ? CH_RSQUARE : CH_RPAREN);
            else
                emit($urandom_range(0, 1) ? CH_LSQUARE : CH_LPAREN);
        end
        else if (pick < 45)
        begin
            emit(CH_QUOTE);
            repeat ($urandom_range(0, 6))
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    emit(CH_CARET);
                    emit(8'($urandom_range(0, 255)));
                end
                else
                    emit(plain_byte());
            end
            emit(CH_QUOTE);
        end
        else if (pick < 60)
        begin
            emit(CH_LBRACE);
            nest = 1;
            repeat ($urandom_range(0, 8))
            begin
                k = $urandom_range(0, 5);
                if (k == 0)
                begin
                    emit(CH_LBRACE);
                    nest++;
                end
                else if (k == 1 && nest > 1)
                begin
                    emit(CH_RBRACE);
                    nest--;
                end
                else if (k == 2)
                begin
                    emit(CH_CARET);
                    emit(8'($urandom_range(0, 255)));
                end
                else
                    emit(plain_byte());
            end
            repeat (nest) emit(CH_RBRACE);
        end
        else if (pick < 75)
        begin
            k = $urandom_range(1, 4);
            repeat (k) emit(CH_PERCENT);
            emit(CH_LBRACE);
            repeat ($urandom_range(0, 5))
            begin
                if ($urandom_range(0, 2) == 0)
                begin
                    emit(CH_RBRACE);
                    repeat ($urandom_range(0, k - 1)) emit(CH_PERCENT);
                end
                emit(plain_byte());
            end
            emit(CH_RBRACE);
            repeat ($urandom_range(k, k + 2)) emit(CH_PERCENT);
            emit(plain_byte());
        end
        else if (pick < 80)
        begin
            emit(CH_PERCENT);
            emit(CH_QUOTE);
            repeat ($urandom_range(0, 3)) emit(plain_byte());
            emit(CH_QUOTE);
        end
        else if (pick < 85)
        begin
            repeat ($urandom_range(1, 5)) emit(CH_PERCENT);
            b = 8'($urandom_range(0, 255));
            emit((b == CH_LBRACE) ? 8'h41 : b);
        end
        else if (pick < 95)
            emit_raw(8'h0a, 1'b1);
        else if (pick < 97)
        begin
            offer_byte('{OP_ABORT, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1))},
                       1'b0, NO_WANT);
            random_sent++;
        end
        else
        begin
            case ($urandom_range(0, 8))
                0: b = CH_QUOTE;
                1: b = CH_PERCENT;
                2: b = CH_LPAREN;
                3: b = CH_RPAREN;
                4: b = CH_LSQUARE;
                5: b = CH_RSQUARE;
                6: b = CH_CARET;
                7: b = CH_LBRACE;
                default: b = CH_RBRACE;
            endcase
            emit_raw(b, 1'($urandom_range(0, 1)));
        end
    endtask

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        int n;
        result_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold_req)
            begin
                long_hold_req = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else
            begin
                n = gap_len(recv_busy);
                if (n > 0)
                begin
                    result_stall <= 1'b1;
                    repeat (n) @(posedge clk);
                end
                result_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (rst_n === 1'b1 && result_valid === 1'b1 && result_stall === 1'b0)
        begin
            if (awaited_scans.size() == 0)
                flag_mismatch($sformatf("result %h with no byte outstanding", result_item));
            else
            begin
                want = awaited_scans.pop_front();
                if (result_item.nest_depth !== want.nest_depth)
                    flag_mismatch($sformatf("nest_depth %0d, want %0d",
                                            result_item.nest_depth, want.nest_depth));
                if (result_item.open_kind !== want.open_kind)
                    flag_mismatch($sformatf("open_kind %0d, want %0d",
                                            result_item.open_kind, want.open_kind));
                if (result_item.scan_mode !== want.scan_mode)
                    flag_mismatch($sformatf("scan_mode %0d, want %0d",
                                            result_item.scan_mode, want.scan_mode));
                if (result_item.input_complete !== want.input_complete)
                    flag_mismatch($sformatf("input_complete %0b, want %0b",
                                            result_item.input_complete, want.input_complete));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((byte_valid === 1'b1 && byte_stall === 1'b0) ||
            (result_valid === 1'b1 && result_stall === 1'b0))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("console_nesting_scanner_unit verification failed");
        $finish;
    end

    initial
    begin
        int row;
        int i;
        rst_n      <= 1'b0;
        byte_valid <= 1'b0;
        byte_item  <= '0;
        clear_scanner();
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < 26; row++)
            offer_byte(PLAN[row].item, PLAN[row].typed, PLAN[row].want);
        drain_results();

        // climb past the stack, back down across its top, with results held off at its start
        send_busy     = 1'b0;
        long_hold_req = 1'b1;
        for (i = 0; i < STACK_DEPTH + 6; i++)
            offer_byte('{OP_SCAN, $urandom_range(0, 1) ? CH_LSQUARE : CH_LPAREN, 1'b0},
                       1'b0, NO_WANT);
        repeat (40) offer_byte('{OP_SCAN, CH_RPAREN, 1'b0}, 1'b0, NO_WANT);
        offer_byte('{OP_ABORT, 8'h00, 1'b0}, 1'b0, NO_WANT);
        drain_results();

        send_busy = 1'b1;
        recv_busy = 1'b1;
        while (random_sent < RANDOM_ITEMS)
        begin
            if (random_sent % 150 < 8)
            begin
                send_busy = ($urandom_range(0, 3) != 0);
                recv_busy = ($urandom_range(0, 3) != 0);
            end
            random_phrase();
        end
        drain_results();
        repeat (8) @(posedge clk);

        if (mismatch_count == 0)
            $display("console_nesting_scanner_unit verification clean");
        else
            $display("console_nesting_scanner_unit verification failed");
        $finish;
    end

endmodule
